[src/hrsp_pkg.sv]
// Package for the HTTP request stream parser: phase codes, result kinds,
// error codes and character helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hrsp_pkg;

	localparam int LengthWidthDefault = 32;

	localparam logic [3:0] KIND_METHOD  = 4'd0;
	localparam logic [3:0] KIND_PATH    = 4'd1;
	localparam logic [3:0] KIND_QUERY   = 4'd2;
	localparam logic [3:0] KIND_VERSION = 4'd3;
	localparam logic [3:0] KIND_NAME    = 4'd4;
	localparam logic [3:0] KIND_VALUE   = 4'd5;
	localparam logic [3:0] KIND_HDR_END = 4'd6;
	localparam logic [3:0] KIND_HDRS    = 4'd7;
	localparam logic [3:0] KIND_BODY    = 4'd8;
	localparam logic [3:0] KIND_ERROR   = 4'd9;

	localparam logic [3:0] ERR_METHOD  = 4'd0;
	localparam logic [3:0] ERR_SPACE   = 4'd1;
	localparam logic [3:0] ERR_SLASH   = 4'd2;
	localparam logic [3:0] ERR_QUERY   = 4'd3;
	localparam logic [3:0] ERR_VERSION = 4'd4;
	localparam logic [3:0] ERR_LINE    = 4'd5;
	localparam logic [3:0] ERR_HEADER  = 4'd6;
	localparam logic [3:0] ERR_BLANK   = 4'd7;
	localparam logic [3:0] ERR_CSIZE   = 4'd8;
	localparam logic [3:0] ERR_CEND    = 4'd9;
	localparam logic [3:0] ERR_FINAL   = 4'd10;
	localparam logic [3:0] ERR_OVERFLOW = 4'd11;

	localparam logic [1:0] METHOD_GET    = 2'd0;
	localparam logic [1:0] METHOD_POST   = 2'd1;
	localparam logic [1:0] METHOD_DELETE = 2'd2;

	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_LENGTH  = 2'd1;
	localparam logic [1:0] MODE_CHUNKED = 2'd2;

	typedef enum logic [30:0] {
		PH_METHOD      = 31'h0000_0001,
		PH_SLASH       = 31'h0000_0002,
		PH_PATH        = 31'h0000_0004,
		PH_V0          = 31'h0000_0008,
		PH_V1          = 31'h0000_0010,
		PH_V2          = 31'h0000_0020,
		PH_V3          = 31'h0000_0040,
		PH_V4          = 31'h0000_0080,
		PH_VMAJ        = 31'h0000_0100,
		PH_VDOT        = 31'h0000_0200,
		PH_VMIN        = 31'h0000_0400,
		PH_RL_CR       = 31'h0000_0800,
		PH_RL_LF       = 31'h0000_1000,
		PH_LINE_START  = 31'h0000_2000,
		PH_NAME        = 31'h0000_4000,
		PH_SKIP        = 31'h0000_8000,
		PH_VALUE       = 31'h0001_0000,
		PH_HDR_LF      = 31'h0002_0000,
		PH_BLANK_LF    = 31'h0004_0000,
		PH_BODY        = 31'h0008_0000,
		PH_CSIZE_FIRST = 31'h0010_0000,
		PH_CSIZE       = 31'h0020_0000,
		PH_CEXT        = 31'h0040_0000,
		PH_CSIZE_LF    = 31'h0080_0000,
		PH_CDATA       = 31'h0100_0000,
		PH_CDATA_CR    = 31'h0200_0000,
		PH_CDATA_LF    = 31'h0400_0000,
		PH_FINAL_CR    = 31'h0800_0000,
		PH_FINAL_LF    = 31'h1000_0000,
		PH_DONE        = 31'h2000_0000,
		PH_ERROR       = 31'h4000_0000
	} phase_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] byte_out;
		logic [1:0] method_code;
		logic [3:0] version_major;
		logic [3:0] version_minor;
		logic [1:0] body_mode;
		logic [3:0] error_code;
		logic       request_done;
	} result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b inside {["A":"Z"]}) ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] p);
		case (p)
			5'd0: return "t";
			5'd1: return "r";
			5'd2: return "a";
			5'd3: return "n";
			5'd4: return "s";
			5'd5: return "f";
			5'd6: return "e";
			5'd7: return "r";
			5'd8: return "-";
			5'd9: return "e";
			5'd10: return "n";
			5'd11: return "c";
			5'd12: return "o";
			5'd13: return "d";
			5'd14: return "i";
			5'd15: return "n";
			5'd16: return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] p);
		case (p)
			5'd0: return "c";
			5'd1: return "o";
			5'd2: return "n";
			5'd3: return "t";
			5'd4: return "e";
			5'd5: return "n";
			5'd6: return "t";
			5'd7: return "-";
			5'd8: return "l";
			5'd9: return "e";
			5'd10: return "n";
			5'd11: return "g";
			5'd12: return "t";
			5'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ch_char(input logic [2:0] p);
		case (p)
			3'd0: return "c";
			3'd1: return "h";
			3'd2: return "u";
			3'd3: return "n";
			3'd4: return "k";
			3'd5: return "e";
			3'd6: return "d";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ver_char(input phase_t p);
		case (p)
			PH_V0: return "H";
			PH_V1: return "T";
			PH_V2: return "T";
			PH_V3: return "P";
			default: return "/";
		endcase
	endfunction

	function automatic phase_t ver_next(input phase_t p);
		case (p)
			PH_V0: return PH_V1;
			PH_V1: return PH_V2;
			PH_V2: return PH_V3;
			PH_V3: return PH_V4;
			default: return PH_VMAJ;
		endcase
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return b inside {["0":"9"], ["a":"f"], ["A":"F"]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [7:0] t;
		t = 8'd0;
		if (b inside {["0":"9"]}) t = b - "0";
		else if (b inside {["a":"f"]}) t = b - "a" + 8'd10;
		else t = b - "A" + 8'd10;
		return t[3:0];
	endfunction

endpackage
`default_nettype wire

[src/http_request_stream_parser.sv]
// HTTP request stream parser, one request byte per word.
// Usage: s_axis carries raw bytes (tdata) and a restart flag (tuser); a
// byte with tuser set restarts parsing at the request line. m_axis carries
// zero or one result word per input byte: tuser gives the kind (method,
// path/query byte, version, header name/value byte, header end, headers
// done, body byte or error), tdata the fields. tlast marks the word that
// completes a request.
// Pipeline: input register, then result register; the parse step lies
// between them, and the parse state is registered together with the result.
// Throughput: one byte per cycle while the result register is empty or
// m_axis_tready is high.
// Reset: the parser waits for a request line, both pipeline stages empty.
// Stall: when m_axis_tready is low the result is held; an empty input
// register still takes one byte, then s_axis_tready drops.
// After an error or a completed request, bytes are dropped until a byte
// with tuser set arrives.
// Depends on hrsp_pkg and hrsp_core.
`timescale 1ns / 1ps
`default_nettype none
module http_request_stream_parser #(
	parameter int LENGTH_WIDTH = hrsp_pkg::LengthWidthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // byte_in
	input  wire logic        s_axis_tuser,  // new_request
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// byte_out[7:0], method_code[9:8], version_major[13:10],
	// version_minor[17:14], body_mode[19:18], error_code[23:20]
	output logic [23:0]      m_axis_tdata,
	output logic [3:0]       m_axis_tuser,  // kind
	output logic             m_axis_tlast   // request_done
);
	import hrsp_pkg::*;

	result_t res;

	hrsp_core #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_new    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	assign m_axis_tdata = {res.error_code, res.body_mode, res.version_minor,
		res.version_major, res.method_code, res.byte_out};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.request_done;
endmodule
`default_nettype wire

[src/hrsp_core.sv]
// Parser core: input register, one-byte parse step, result register.
// Depends on hrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hrsp_core #(
	parameter int LENGTH_WIDTH = hrsp_pkg::LengthWidthDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_new,
	output logic                  in_ready,
	output logic                  res_valid,
	output hrsp_pkg::result_t     res,
	input  wire logic             res_ready
);
	import hrsp_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] b_s1;
	logic       n_s1;
	logic       adv;

	phase_t                  phase_q;
	logic [47:0]             mchars_q;
	logic [2:0]              mcount_q;
	logic                    qseen_q;
	logic [4:0]              npos_q;
	logic [1:0]              nflags_q;
	logic [2:0]              vpos_q;
	logic [1:0]              nonempty_q;
	logic [LENGTH_WIDTH-1:0] vacc_q;
	logic                    chunked_q;
	logic                    lenflag_q;
	logic [LENGTH_WIDTH-1:0] blen_q;
	logic [LENGTH_WIDTH-1:0] rem_q;
	logic [3:0]              major_q;

	phase_t                  phase_d;
	logic [47:0]             mchars_d;
	logic [2:0]              mcount_d;
	logic                    qseen_d;
	logic [4:0]              npos_d;
	logic [1:0]              nflags_d;
	logic [2:0]              vpos_d;
	logic [1:0]              nonempty_d;
	logic [LENGTH_WIDTH-1:0] vacc_d;
	logic                    chunked_d;
	logic                    lenflag_d;
	logic [LENGTH_WIDTH-1:0] blen_d;
	logic [LENGTH_WIDTH-1:0] rem_d;
	logic [3:0]              major_d;

	logic    emit;
	result_t r;

	assign adv      = !res_valid || res_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			b_s1 <= in_byte;
			n_s1 <= in_new;
		end
	end

	always_comb begin
		phase_t     ph;
		logic [47:0] mc;
		logic [2:0]  mn;
		logic        qs;
		logic [4:0]  np;
		logic [1:0]  nf;
		logic [2:0]  vp;
		logic [1:0]  ne;
		logic [LENGTH_WIDTH-1:0] va;
		logic        ck;
		logic        lf;
		logic [LENGTH_WIDTH-1:0] bl;
		logic [LENGTH_WIDTH-1:0] rm;
		logic [3:0]  mj;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [LENGTH_WIDTH-1:0] rdec;
		logic [LENGTH_WIDTH+3:0] prod10;
		logic [LENGTH_WIDTH+4:0] sum10;
		logic [LENGTH_WIDTH+4:0] sum16;

		b  = b_s1;
		c  = to_lower(b);
		ph = phase_q; mc = mchars_q; mn = mcount_q; qs = qseen_q;
		np = npos_q; nf = nflags_q; vp = vpos_q; ne = nonempty_q;
		va = vacc_q; ck = chunked_q; lf = lenflag_q; bl = blen_q;
		rm = rem_q; mj = major_q;
		if (n_s1) begin
			ph = PH_METHOD; mc = '0; mn = '0; qs = 1'b0; np = '0; nf = '0;
			vp = '0; ne = '0; va = '0; ck = 1'b0; lf = 1'b0; bl = '0; rm = '0;
			mj = '0;
		end
		emit = 1'b0;
		r    = '0;
		rdec = (rm != '0) ? rm - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1} : rm;
		prod10 = {1'b0, va, 3'b000} + {3'b000, va, 1'b0};
		sum10  = {1'b0, prod10} + {{(LENGTH_WIDTH-3){1'b0}}, b - 8'h30};
		sum16  = {1'b0, rm, 4'h0} + {{(LENGTH_WIDTH+1){1'b0}}, hex_val(b)};

		case (ph)
			PH_METHOD: begin
				if (b == " ") begin
					emit = 1'b1;
					if (mn == 3'd3 && mc == 48'h474554) begin
						r.kind = KIND_METHOD; r.method_code = METHOD_GET; ph = PH_SLASH;
					end else if (mn == 3'd4 && mc == 48'h504F5354) begin
						r.kind = KIND_METHOD; r.method_code = METHOD_POST; ph = PH_SLASH;
					end else if (mn == 3'd6 && mc == 48'h44454C455445) begin
						r.kind = KIND_METHOD; r.method_code = METHOD_DELETE; ph = PH_SLASH;
					end else begin
						r.kind = KIND_ERROR; r.error_code = ERR_METHOD; ph = PH_ERROR;
					end
				end else if (mn >= 3'd6) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_METHOD; ph = PH_ERROR;
				end else begin
					mc = {mc[39:0], b};
					mn = mn + 3'd1;
				end
			end
			PH_SLASH: begin
				if (b != "/") begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_SLASH; ph = PH_ERROR;
				end else ph = PH_PATH;
			end
			PH_PATH: begin
				if (b == " ") ph = PH_V0;
				else if (b == "?") begin
					if (qs) begin
						emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_QUERY; ph = PH_ERROR;
					end else qs = 1'b1;
				end else if (b inside {8'h0d, 8'h0a}) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_SPACE; ph = PH_ERROR;
				end else begin
					emit = 1'b1; r.kind = qs ? KIND_QUERY : KIND_PATH; r.byte_out = b;
				end
			end
			PH_V0, PH_V1, PH_V2, PH_V3, PH_V4: begin
				if (b != ver_char(ph)) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_VERSION; ph = PH_ERROR;
				end else ph = ver_next(ph);
			end
			PH_VMAJ: begin
				if (!(b inside {["0":"9"]})) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_VERSION; ph = PH_ERROR;
				end else begin
					mj = b[3:0]; ph = PH_VDOT;
				end
			end
			PH_VDOT: begin
				if (b != ".") begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_VERSION; ph = PH_ERROR;
				end else ph = PH_VMIN;
			end
			PH_VMIN: begin
				emit = 1'b1;
				if (!(b inside {["0":"9"]})) begin
					r.kind = KIND_ERROR; r.error_code = ERR_VERSION; ph = PH_ERROR;
				end else begin
					r.kind = KIND_VERSION; r.version_major = mj; r.version_minor = b[3:0];
					ph = PH_RL_CR;
				end
			end
			PH_RL_CR: begin
				if (b != 8'h0d) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_LINE; ph = PH_ERROR;
				end else ph = PH_RL_LF;
			end
			PH_RL_LF: begin
				if (b != 8'h0a) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_LINE; ph = PH_ERROR;
				end else begin
					np = '0; nf = 2'b11; vp = '0; ne = '0; va = '0; ph = PH_LINE_START;
				end
			end
			PH_LINE_START, PH_NAME: begin
				if (ph == PH_LINE_START && b == 8'h0d) ph = PH_BLANK_LF;
				else if (b == ":") begin
					if (nf[0] && np == 5'd17) nf = 2'b01;
					else if (nf[1] && np == 5'd14) nf = 2'b10;
					else begin
						nf = 2'b00; np = '0;
					end
					ph = PH_SKIP;
				end else if (b inside {8'h0d, 8'h0a}) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_HEADER; ph = PH_ERROR;
				end else begin
					ph = PH_NAME;
					ne[0] = 1'b1;
					if (np >= 5'd17 || c != te_char(np)) nf[0] = 1'b0;
					if (np >= 5'd14 || c != cl_char(np)) nf[1] = 1'b0;
					if (np < 5'd31) np = np + 5'd1;
					emit = 1'b1; r.kind = KIND_NAME; r.byte_out = b;
				end
			end
			PH_SKIP: ph = PH_VALUE;
			PH_VALUE: begin
				if (b == 8'h0d) ph = PH_HDR_LF;
				else if (b == 8'h0a) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_HEADER; ph = PH_ERROR;
				end else begin
					ne[1] = 1'b1;
					emit = 1'b1; r.kind = KIND_VALUE; r.byte_out = b;
					if (np == 5'd17 && nf[0]) begin
						if (vp < 3'd7 && c == ch_char(vp)) vp = vp + 3'd1;
						else nf = 2'b00;
					end
					if (nf[1] && !vp[0]) begin
						if (b inside {["0":"9"]}) begin
							if (sum10[LENGTH_WIDTH+4:LENGTH_WIDTH] != '0) begin
								r = '0; r.kind = KIND_ERROR; r.error_code = ERR_OVERFLOW;
								ph = PH_ERROR;
							end else va = sum10[LENGTH_WIDTH-1:0];
						end else vp = 3'd1;
					end
				end
			end
			PH_HDR_LF: begin
				emit = 1'b1;
				if (b != 8'h0a) begin
					r.kind = KIND_ERROR; r.error_code = ERR_HEADER; ph = PH_ERROR;
				end else begin
					if (ne == 2'b11) begin
						if (np == 5'd17) ck = nf[0] && vp == 3'd7;
						if (nf[1]) begin
							lf = 1'b1; bl = va;
						end
					end
					np = '0; nf = 2'b11; vp = '0; ne = '0; va = '0;
					ph = PH_LINE_START;
					r.kind = KIND_HDR_END;
				end
			end
			PH_BLANK_LF: begin
				emit = 1'b1;
				if (b != 8'h0a) begin
					r.kind = KIND_ERROR; r.error_code = ERR_BLANK; ph = PH_ERROR;
				end else begin
					r.kind = KIND_HDRS;
					if (ck) begin
						r.body_mode = MODE_CHUNKED; ph = PH_CSIZE_FIRST;
					end else if (lf) begin
						r.body_mode = MODE_LENGTH;
						if (bl == '0) begin
							r.request_done = 1'b1; ph = PH_DONE;
						end else begin
							rm = bl; ph = PH_BODY;
						end
					end else begin
						r.body_mode = MODE_NONE; r.request_done = 1'b1; ph = PH_DONE;
					end
				end
			end
			PH_BODY: begin
				emit = 1'b1; r.kind = KIND_BODY; r.byte_out = b;
				rm = rdec;
				if (rdec == '0) begin
					r.request_done = 1'b1; ph = PH_DONE;
				end
			end
			PH_CSIZE_FIRST: begin
				if (!is_hex(b)) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_CSIZE; ph = PH_ERROR;
				end else begin
					rm = {{(LENGTH_WIDTH-4){1'b0}}, hex_val(b)}; ph = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				if (is_hex(b)) begin
					if (sum16[LENGTH_WIDTH+4:LENGTH_WIDTH] != '0) begin
						emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_OVERFLOW;
						ph = PH_ERROR;
					end else rm = sum16[LENGTH_WIDTH-1:0];
				end else ph = (b == 8'h0d) ? PH_CSIZE_LF : PH_CEXT;
			end
			PH_CEXT: if (b == 8'h0d) ph = PH_CSIZE_LF;
			PH_CSIZE_LF: begin
				if (b != 8'h0a) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_CSIZE; ph = PH_ERROR;
				end else ph = (rm != '0) ? PH_CDATA : PH_FINAL_CR;
			end
			PH_CDATA: begin
				rm = rdec;
				if (rdec == '0) ph = PH_CDATA_CR;
				emit = 1'b1; r.kind = KIND_BODY; r.byte_out = b;
			end
			PH_CDATA_CR: begin
				if (b != 8'h0d) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_CEND; ph = PH_ERROR;
				end else ph = PH_CDATA_LF;
			end
			PH_CDATA_LF: begin
				if (b != 8'h0a) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_CEND; ph = PH_ERROR;
				end else ph = PH_CSIZE_FIRST;
			end
			PH_FINAL_CR: begin
				if (b != 8'h0d) begin
					emit = 1'b1; r.kind = KIND_ERROR; r.error_code = ERR_FINAL; ph = PH_ERROR;
				end else ph = PH_FINAL_LF;
			end
			PH_FINAL_LF: begin
				emit = 1'b1;
				if (b != 8'h0a) begin
					r.kind = KIND_ERROR; r.error_code = ERR_FINAL; ph = PH_ERROR;
				end else begin
					r.kind = KIND_HDRS; r.body_mode = MODE_CHUNKED; r.request_done = 1'b1;
					ph = PH_DONE;
				end
			end
			default: ;
		endcase

		phase_d = ph; mchars_d = mc; mcount_d = mn; qseen_d = qs; npos_d = np;
		nflags_d = nf; vpos_d = vp; nonempty_d = ne; vacc_d = va; chunked_d = ck;
		lenflag_d = lf; blen_d = bl; rem_d = rm; major_d = mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD; mchars_q <= '0; mcount_q <= '0; qseen_q <= 1'b0;
			npos_q <= '0; nflags_q <= '0; vpos_q <= '0; nonempty_q <= '0;
			vacc_q <= '0; chunked_q <= 1'b0; lenflag_q <= 1'b0; blen_q <= '0;
			rem_q <= '0; major_q <= '0;
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= v_s1 && emit;
			if (v_s1) begin
				phase_q <= phase_d; mchars_q <= mchars_d; mcount_q <= mcount_d;
				qseen_q <= qseen_d; npos_q <= npos_d; nflags_q <= nflags_d;
				vpos_q <= vpos_d; nonempty_q <= nonempty_d; vacc_q <= vacc_d;
				chunked_q <= chunked_d; lenflag_q <= lenflag_d; blen_q <= blen_d;
				rem_q <= rem_d; major_q <= major_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && emit) res <= r;
	end
endmodule
`default_nettype wire
